[rtl/core/osr_pkg.sv]
package osr_pkg;

  // default sizing of the stack
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WIDTH_DEF = 32;

  // command codes
  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_DUP   = 3'd3,
    OP_SWAP  = 3'd4,
    OP_ROLL  = 3'd5,
    OP_CLEAR = 3'd6
  } op_e;

  // result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FEW   = 2'd2;
  localparam logic [1:0] STS_OVER  = 2'd3;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_SHIFT
  } state_e;

  // datapath action taken when a command is accepted
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_DUP,
    ACT_POP_LAST,
    ACT_POP_READ,
    ACT_ROLL_READ,
    ACT_CLEAR
  } act_e;

  // input transaction
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] push_value;
    logic [3:0]  roll_depth;
  } osr_in_t;

  // result transaction
  typedef struct packed {
    logic [31:0] top_value;
    logic        top_valid;
    logic        is_empty;
    logic [4:0]  depth_used;
    logic [1:0]  status;
  } osr_out_t;

  // controller to datapath
  typedef struct packed {
    act_e       act;
    logic       rd;
    logic       load;
    logic       shift;
    logic       finish;
    logic [1:0] status;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic single;
    logic fits;
    logic amt_zero;
    logic last;
  } dp_status_t;

endpackage

[rtl/core/osr_ram.sv]
module osr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/osr_ctrl.sv]
module osr_ctrl
  import osr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op_i,
  input  dp_status_t dp_i,
  output ctl_cmd_t   cmd_o
);

  state_e     state_q, state_d;
  logic       pop_q, pop_d;
  logic       accept;
  act_e       act_dec;
  logic [1:0] sts_dec;
  logic       multi;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // command decode against current stack condition
  always_comb begin
    act_dec = ACT_NONE;
    sts_dec = STS_OK;
    case (op_e'(op_i))
      OP_PUSH: begin
        if (dp_i.full) sts_dec = STS_OVER;
        else act_dec = ACT_PUSH;
      end
      OP_POP: begin
        if (dp_i.empty) sts_dec = STS_EMPTY;
        else if (dp_i.single) act_dec = ACT_POP_LAST;
        else act_dec = ACT_POP_READ;
      end
      OP_PEEK: begin
        if (dp_i.empty) sts_dec = STS_EMPTY;
      end
      OP_DUP: begin
        if (dp_i.empty) sts_dec = STS_EMPTY;
        else if (dp_i.full) sts_dec = STS_OVER;
        else act_dec = ACT_DUP;
      end
      OP_SWAP, OP_ROLL: begin
        if (dp_i.empty) sts_dec = STS_EMPTY;
        else if (!dp_i.fits) sts_dec = STS_FEW;
        else if (!dp_i.amt_zero) act_dec = ACT_ROLL_READ;
      end
      OP_CLEAR: begin
        act_dec = ACT_CLEAR;
      end
      default: begin
        act_dec = ACT_NONE;
      end
    endcase
  end

  assign multi = (act_dec inside {ACT_POP_READ, ACT_ROLL_READ});

  // next state
  always_comb begin
    state_d = state_q;
    pop_d   = pop_q;
    case (state_q)
      S_IDLE: begin
        if (accept && multi) begin
          state_d = S_READ;
          pop_d   = (act_dec == ACT_POP_READ);
        end
      end
      S_READ: begin
        state_d = pop_q ? S_LOAD : S_SHIFT;
      end
      S_LOAD: begin
        state_d = S_IDLE;
      end
      S_SHIFT: begin
        if (dp_i.last) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs to the datapath
  always_comb begin
    cmd_o = '{act: ACT_NONE, rd: 1'b0, load: 1'b0, shift: 1'b0, finish: 1'b0,
              status: STS_OK};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.act    = act_dec;
          cmd_o.finish = !multi;
          cmd_o.status = sts_dec;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
      end
      S_LOAD: begin
        cmd_o.load   = 1'b1;
        cmd_o.finish = 1'b1;
      end
      S_SHIFT: begin
        cmd_o.shift  = 1'b1;
        cmd_o.finish = dp_i.last;
      end
      default: begin
        cmd_o.finish = 1'b0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pop_q   <= pop_d;
    end
  end

`ifndef ASSERT_OFF
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.finish && state_q != S_IDLE) |=> state_q == S_IDLE)
    else $error("multi-cycle command did not return to idle");
  a_read_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> $past(state_q) == S_IDLE)
    else $error("read phase not entered from idle");
  a_no_act_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> cmd_o.act == ACT_NONE)
    else $error("accept action issued while busy");
`endif

endmodule

[rtl/core/osr_dpath.sv]
module osr_dpath
  import osr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  osr_in_t    in_i,
  input  ctl_cmd_t   cmd_i,
  output dp_status_t dp_o,
  output logic       done_o,
  output osr_out_t   res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    count_q, count_d;
  logic [WIDTH-1:0] top_q, top_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [AW-1:0]    last_q, last_d;
  logic             done_q;
  osr_out_t         res_q, res_d;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [WIDTH-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [WIDTH-1:0] rdata;

  logic [3:0]       amount;
  logic [63:0]      push_wide;
  logic [WIDTH-1:0] push_val;
  logic [63:0]      top_wide;
  logic [31:0]      cnt_wide;

  // swap is a roll by one
  assign amount    = (op_e'(in_i.op) == OP_SWAP) ? 4'd1 : in_i.roll_depth;
  assign push_wide = 64'(in_i.push_value);
  assign push_val  = push_wide[WIDTH-1:0];

  // stack condition seen by the controller
  assign dp_o.empty    = (count_q == '0);
  assign dp_o.full     = (count_q >= CW'(DEPTH));
  assign dp_o.single   = (count_q == CW'(1));
  assign dp_o.fits     = (32'(count_q) > 32'(amount));
  assign dp_o.amt_zero = (amount == 4'd0);
  assign dp_o.last     = (ptr_q == last_q);

  // top element lives in top_q, the rest below it in the ram
  always_comb begin
    count_d = count_q;
    top_d   = top_q;
    ptr_d   = ptr_q;
    last_d  = last_q;
    we      = 1'b0;
    waddr   = AW'(32'(count_q) - 32'd1);
    wdata   = top_q;
    case (cmd_i.act)
      ACT_PUSH: begin
        we      = !dp_o.empty;
        top_d   = push_val;
        count_d = count_q + CW'(1);
      end
      ACT_DUP: begin
        we      = 1'b1;
        count_d = count_q + CW'(1);
      end
      ACT_POP_LAST: begin
        count_d = count_q - CW'(1);
      end
      ACT_POP_READ: begin
        count_d = count_q - CW'(1);
        ptr_d   = AW'(32'(count_q) - 32'd2);
      end
      ACT_ROLL_READ: begin
        ptr_d  = AW'(32'(count_q) - 32'd1 - 32'(amount));
        last_d = AW'(32'(count_q) - 32'd2);
      end
      ACT_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    // refill the top after a pop
    if (cmd_i.load) begin
      top_d = rdata;
    end
    // roll step: carried element goes down, the one read comes up
    if (cmd_i.shift) begin
      we    = 1'b1;
      waddr = ptr_q;
      wdata = top_q;
      top_d = rdata;
      ptr_d = ptr_q + AW'(1);
    end
  end

  // read the issued entry, then run one entry ahead while shifting
  assign raddr = cmd_i.rd ? ptr_q : ptr_q + AW'(1);

  // result fields from the state after the command
  assign top_wide = 64'(top_d);
  assign cnt_wide = 32'(count_d);
  always_comb begin
    res_d.top_value  = (count_d == '0) ? 32'd0 : top_wide[31:0];
    res_d.top_valid  = (count_d != '0);
    res_d.is_empty   = (count_d == '0);
    res_d.depth_used = cnt_wide[4:0];
    res_d.status     = cmd_i.status;
  end

  osr_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.finish;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    ptr_q  <= ptr_d;
    last_q <= last_d;
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("element count above depth");
  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> res_q.top_valid != res_q.is_empty)
    else $error("top valid and empty flags disagree");
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> (32'(ptr_q) + 32'd1 < 32'(count_q)))
    else $error("roll step writes at or above the top");
`endif

endmodule

[rtl/core/operand_stack_with_roll.sv]
// push, peek, duplicate, clear, pop of a sole element, roll by zero and refused commands
// give done_o in the cycle after start; pop with two or more elements goes through the read
// and load states, busy in both; roll by n (swap is n = 1) reads, then moves one ram entry a
// cycle in the shift state, n entries in all; a new start is taken while done_o is high
// reset clears count, done_o and state; the element ram is not cleared and needs no pass
// results are shown for one cycle on done_o; the receiver cannot stall them
module operand_stack_with_roll
  import osr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  osr_in_t  in_i,
  output logic     done_o,
  output osr_out_t res_o
);

  ctl_cmd_t   cmd;
  dp_status_t dp_stat;

  // sequencer
  osr_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .op_i  (in_i.op),
    .dp_i  (dp_stat),
    .cmd_o (cmd)
  );

  // stack storage and result register
  osr_dpath #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_dpath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .cmd_i (cmd),
    .dp_o  (dp_stat),
    .done_o(done_o),
    .res_o (res_o)
  );

endmodule
